// ===== rtl/core/pfr_pkg.sv =====
package pfr_pkg;

   localparam logic [1:0] MODE_DRAW  = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_START = 2'd2;
   localparam logic [1:0] MODE_PULL  = 2'd3;

   localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
   localparam logic [7:0] CMD_COL_LOW   = 8'h00;
   localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] column;
      logic [7:0] row;
      logic       pixel_on;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_data;
      logic       byte_valid;
      logic       refresh_done;
      logic       point_rejected;
   } rsp_type;

endpackage

// ===== rtl/core/pfr_store.sv =====
module pfr_store #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data
);

   logic [7:0]        mem [DEPTH];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] rd_addr_ff;
   logic              fwd_valid_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic [7:0]        fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff  <= mem[rd_addr];
      rd_addr_ff  <= rd_addr;
      fwd_addr_ff <= wr_addr;
      fwd_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= wr_en;
      end
   end

   // write landing on the same edge as the read wins
   assign rd_data = (fwd_valid_ff && (fwd_addr_ff == rd_addr_ff)) ? fwd_data_ff : rd_data_ff;

endmodule

// ===== rtl/core/paged_pixel_framebuffer_refresher_top.sv =====
// an accepted request gives its rsp_valid strobe through s1_valid_ff and then rsp_valid_ff
// throughput: one request per cycle for draw, start and pull requests while busy is low
// a clear request holds busy high while the store is zeroed, all COLUMNS*PAGES bytes
// (1024 by default), one byte per cycle through the single write port
// reset runs the same zeroing pass; no request is taken until it ends
// the receiver cannot stall: each result is shown for exactly one cycle
module paged_pixel_framebuffer_refresher_top import pfr_pkg::*; #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_payload,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_payload
);

   localparam int DEPTH    = COLUMNS * PAGES;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int PAGE_W   = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int POS_W    = $clog2(COLUMNS + 3);
   localparam int ROWS     = PAGES * 8;
   localparam int LAST_POS = COLUMNS + 2;

   localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(PAGES - 1);
   localparam logic [POS_W-1:0]  POS_END   = POS_W'(LAST_POS);
   localparam logic [8:0]        COL_LIM   = 9'(COLUMNS);
   localparam logic [8:0]        ROW_LIM   = 9'(ROWS);

   typedef struct packed {
      logic              write;
      logic              pixel_on;
      logic [2:0]        bit_sel;
      logic              from_store;
      logic [7:0]        cmd_byte;
      logic              byte_valid;
      logic              is_data;
      logic              done;
      logic              rejected;
      logic [ADDR_W-1:0] addr;
   } stage_type;

   logic              accept;
   logic              in_range;
   logic [PAGE_W-1:0] draw_page;
   logic [ADDR_W-1:0] draw_addr;
   logic [ADDR_W-1:0] pull_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic [7:0]        bit_mask;
   logic [7:0]        new_byte;

   logic              active_ff, active_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              sweep_active_ff, sweep_active_in;
   logic [ADDR_W-1:0] sweep_addr_ff, sweep_addr_in;
   logic              s1_valid_ff;
   stage_type         s1_ff, s1_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_payload_ff, rsp_payload_in;

   assign busy   = sweep_active_ff;
   assign accept = start && !busy;

   assign in_range  = ({1'b0, req_payload.column} < COL_LIM) &&
                      ({1'b0, req_payload.row} < ROW_LIM);
   assign draw_page = PAGE_W'(req_payload.row >> 3);
   assign draw_addr = ADDR_W'(ADDR_W'(draw_page) * COLS_A + ADDR_W'(req_payload.column));
   assign pull_addr = ADDR_W'(ADDR_W'(page_ff) * COLS_A + ADDR_W'(pos_ff - POS_W'(3)));
   assign rd_addr   = (req_payload.mode == MODE_PULL) ? pull_addr : draw_addr;

   // request decode and refresh walk
   always_comb begin
      s1_in         = '0;
      s1_in.addr    = rd_addr;
      s1_in.pixel_on = req_payload.pixel_on;
      s1_in.bit_sel = req_payload.row[2:0];
      active_in     = active_ff;
      page_in       = page_ff;
      pos_in        = pos_ff;
      if (accept) begin
         case (req_payload.mode)
            MODE_DRAW: begin
               s1_in.write    = in_range;
               s1_in.rejected = !in_range;
            end
            MODE_START: begin
               active_in = 1'b1;
               page_in   = '0;
               pos_in    = '0;
            end
            MODE_PULL: begin
               if (active_ff) begin
                  s1_in.byte_valid = 1'b1;
                  if (pos_ff == POS_W'(0)) begin
                     s1_in.cmd_byte = CMD_PAGE_BASE + 8'(page_ff);
                  end else if (pos_ff == POS_W'(1)) begin
                     s1_in.cmd_byte = CMD_COL_LOW;
                  end else if (pos_ff == POS_W'(2)) begin
                     s1_in.cmd_byte = CMD_COL_HIGH;
                  end else begin
                     s1_in.from_store = 1'b1;
                     s1_in.is_data    = 1'b1;
                  end
                  if (pos_ff == POS_END) begin
                     pos_in = '0;
                     if (page_ff == LAST_PAGE) begin
                        s1_in.done = 1'b1;
                        active_in  = 1'b0;
                        page_in    = '0;
                     end else begin
                        page_in = page_ff + PAGE_W'(1);
                     end
                  end else begin
                     pos_in = pos_ff + POS_W'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // zeroing pass
   always_comb begin
      sweep_active_in = sweep_active_ff;
      sweep_addr_in   = sweep_addr_ff;
      if (sweep_active_ff) begin
         if (sweep_addr_ff == LAST_ADDR) begin
            sweep_active_in = 1'b0;
         end else begin
            sweep_addr_in = sweep_addr_ff + ADDR_W'(1);
         end
      end else if (accept && (req_payload.mode == MODE_CLEAR)) begin
         sweep_active_in = 1'b1;
         sweep_addr_in   = '0;
      end
   end

   // read-modify-write stage
   assign bit_mask = 8'(1) << s1_ff.bit_sel;
   assign new_byte = s1_ff.pixel_on ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
   assign wr_en    = (s1_valid_ff && s1_ff.write) || sweep_active_ff;
   assign wr_addr  = sweep_active_ff ? sweep_addr_ff : s1_ff.addr;
   assign wr_data  = sweep_active_ff ? 8'h00 : new_byte;

   always_comb begin
      rsp_payload_in.out_byte       = s1_ff.from_store ? rd_data : s1_ff.cmd_byte;
      rsp_payload_in.is_data        = s1_ff.is_data;
      rsp_payload_in.byte_valid     = s1_ff.byte_valid;
      rsp_payload_in.refresh_done   = s1_ff.done;
      rsp_payload_in.point_rejected = s1_ff.rejected;
   end

   pfr_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff       <= 1'b0;
         page_ff         <= '0;
         pos_ff          <= '0;
         sweep_active_ff <= 1'b1;
         sweep_addr_ff   <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         active_ff       <= active_in;
         page_ff         <= page_in;
         pos_ff          <= pos_in;
         sweep_active_ff <= sweep_active_in;
         sweep_addr_ff   <= sweep_addr_in;
         s1_valid_ff     <= accept;
         rsp_valid_ff    <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff          <= s1_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid)
      else $error("request without response two cycles later");

   a_done_is_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.refresh_done) |->
         (rsp_payload.byte_valid && rsp_payload.is_data))
      else $error("refresh done on a non-data byte");

   a_reject_no_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.point_rejected) |-> !rsp_payload.byte_valid)
      else $error("rejected point carries a byte");

   a_write_port: assert property (@(posedge clock) disable iff (reset)
      !(s1_valid_ff && s1_ff.write && sweep_active_ff))
      else $error("draw write collides with zeroing pass");

endmodule

// ===== tb/pfr_refresh_checker.sv =====
`timescale 1ns / 100ps
module pfr_refresh_checker import pfr_pkg::*; #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  rsp_type rsp_payload,
   output int      failure_count,
   output int      awaited_count
);

   logic [7:0] frame_bytes [COLUMNS*PAGES];
   logic       scan_active;
   int         scan_page;
   int         scan_position;
   rsp_type    awaited_rsp [$];
   rsp_type    want;
   int         failures = 0;

   function automatic rsp_type apply_request(input req_type req);
      rsp_type rsp;
      int      addr;
      rsp = '0;
      case (req.mode)
         MODE_DRAW: begin
            if (req.column >= COLUMNS || req.row >= PAGES * 8) begin
               rsp.point_rejected = 1'b1;
            end else begin
               addr = (req.row / 8) * COLUMNS + req.column;
               frame_bytes[addr][req.row % 8] = req.pixel_on;
            end
         end
         MODE_CLEAR: begin
            foreach (frame_bytes[i]) frame_bytes[i] = '0;
         end
         MODE_START: begin
            scan_active   = 1'b1;
            scan_page     = 0;
            scan_position = 0;
         end
         MODE_PULL: begin
            if (scan_active) begin
               rsp.byte_valid = 1'b1;
               if (scan_position == 0) begin
                  rsp.out_byte = 8'(CMD_PAGE_BASE + scan_page);
               end else if (scan_position == 1) begin
                  rsp.out_byte = CMD_COL_LOW;
               end else if (scan_position == 2) begin
                  rsp.out_byte = CMD_COL_HIGH;
               end else begin
                  rsp.out_byte = frame_bytes[scan_page * COLUMNS + scan_position - 3];
                  rsp.is_data  = 1'b1;
               end
               if (scan_position >= COLUMNS + 2) begin
                  scan_position = 0;
                  if (scan_page + 1 >= PAGES) begin
                     rsp.refresh_done = 1'b1;
                     scan_active      = 1'b0;
                     scan_page        = 0;
                  end else begin
                     scan_page = scan_page + 1;
                  end
               end else begin
                  scan_position = scan_position + 1;
               end
            end
         end
         default: begin
         end
      endcase
      return rsp;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (frame_bytes[i]) frame_bytes[i] = '0;
         scan_active   = 1'b0;
         scan_page     = 0;
         scan_position = 0;
         awaited_rsp.delete();
      end else begin
         if (rsp_valid) begin
            if (awaited_rsp.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected result: byte %h data %b valid %b done %b rejected %b",
                           rsp_payload.out_byte, rsp_payload.is_data, rsp_payload.byte_valid,
                           rsp_payload.refresh_done, rsp_payload.point_rejected);
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_payload.out_byte !== want.out_byte ||
                   rsp_payload.is_data !== want.is_data ||
                   rsp_payload.byte_valid !== want.byte_valid ||
                   rsp_payload.refresh_done !== want.refresh_done ||
                   rsp_payload.point_rejected !== want.point_rejected) begin
                  failures++;
                  if (failures <= 10)
                     $display({"mismatch at %0t: expected byte %h data %b valid %b done %b ",
                               "rejected %b, got byte %h data %b valid %b done %b rejected %b"},
                              $time, want.out_byte, want.is_data, want.byte_valid,
                              want.refresh_done, want.point_rejected,
                              rsp_payload.out_byte, rsp_payload.is_data,
                              rsp_payload.byte_valid, rsp_payload.refresh_done,
                              rsp_payload.point_rejected);
               end
            end
         end
         if (start && !busy)
            awaited_rsp.push_back(apply_request(req_payload));
      end
      failure_count <= failures;
      awaited_count <= awaited_rsp.size();
   end

endmodule

// ===== tb/paged_pixel_framebuffer_refresher_top_tb.sv =====
`timescale 1ns / 100ps
module paged_pixel_framebuffer_refresher_top_tb import pfr_pkg::*;;

   localparam int COLUMNS      = 128;
   localparam int PAGES        = 8;
   localparam int REQUEST_GOAL = 1700;

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_payload;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_payload;

   int failure_count;
   int awaited_count;
   int sent_count = 0;
   int idle_pct;
   int idle_by_phase [4] = '{0, 62, 0, 16};
   bit full_scan_done = 1'b0;
   int pick;
   int drain_cycles;

   paged_pixel_framebuffer_refresher_top #(
      .COLUMNS(COLUMNS),
      .PAGES  (PAGES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_payload(req_payload),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload)
   );

   pfr_refresh_checker #(
      .COLUMNS(COLUMNS),
      .PAGES  (PAGES)
   ) refresh_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_payload  (rsp_payload),
      .failure_count(failure_count),
      .awaited_count(awaited_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("paged_pixel_framebuffer_refresher_top verification failed");
      $finish;
   end

   function automatic req_type make_req(input logic [1:0] mode, input logic [7:0] column,
                                        input logic [7:0] row, input logic pixel_on);
      req_type req;
      req.mode     = mode;
      req.column   = column;
      req.row      = row;
      req.pixel_on = pixel_on;
      return req;
   endfunction

   // mostly in range, biased toward setting pixels so refresh data is not all zero
   function automatic req_type random_draw();
      if ($urandom_range(99) < 88)
         return make_req(MODE_DRAW, 8'($urandom_range(COLUMNS - 1)),
                         8'($urandom_range(PAGES * 8 - 1)), 1'($urandom_range(99) < 70));
      return make_req(MODE_DRAW, 8'($urandom), 8'($urandom), 1'($urandom));
   endfunction

   task automatic send_request(input req_type req);
      idle_pct = idle_by_phase[(sent_count / 400) % 4];
      while ($urandom_range(99) < idle_pct) begin
         start       <= 1'b0;
         req_payload <= req_type'($urandom);
         @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= req;
      do @(posedge clock); while (busy);
      sent_count++;
   endtask

   task automatic scan_run(input int pulls_wanted);
      int pulls = 0;
      send_request(make_req(MODE_START, 8'($urandom), 8'($urandom), 1'($urandom)));
      while (pulls < pulls_wanted) begin
         if ($urandom_range(99) < 8) begin
            send_request(random_draw());
         end else begin
            send_request(make_req(MODE_PULL, 8'($urandom), 8'($urandom), 1'($urandom)));
            pulls++;
         end
      end
   endtask

   initial begin
      reset       <= 1'b1;
      start       <= 1'b0;
      req_payload <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_request(make_req(MODE_DRAW, 8'd0, 8'd0, 1'b1));
      send_request(make_req(MODE_DRAW, 8'd127, 8'd63, 1'b1));
      send_request(make_req(MODE_DRAW, 8'd128, 8'd0, 1'b1));
      send_request(make_req(MODE_DRAW, 8'd0, 8'd64, 1'b1));
      send_request(make_req(MODE_DRAW, 8'd255, 8'd255, 1'b1));
      send_request(make_req(MODE_DRAW, 8'd127, 8'd63, 1'b0));
      send_request(make_req(MODE_DRAW, 8'd5, 8'd7, 1'b1));
      // pull with no refresh running
      send_request(make_req(MODE_PULL, 8'd0, 8'd0, 1'b0));
      send_request(make_req(MODE_START, 8'd0, 8'd0, 1'b0));
      repeat (4) send_request(make_req(MODE_PULL, 8'd0, 8'd0, 1'b0));
      // restart in the middle of a refresh
      send_request(make_req(MODE_START, 8'd255, 8'd255, 1'b1));
      send_request(make_req(MODE_PULL, 8'd255, 8'd255, 1'b1));
      send_request(make_req(MODE_DRAW, 8'd1, 8'd0, 1'b1));
      repeat (4) send_request(make_req(MODE_PULL, 8'd0, 8'd0, 1'b0));
      // clear during a refresh
      send_request(make_req(MODE_CLEAR, 8'd0, 8'd0, 1'b0));
      send_request(make_req(MODE_START, 8'd0, 8'd0, 1'b0));
      repeat (3) send_request(make_req(MODE_PULL, 8'd0, 8'd0, 1'b0));

      while (sent_count < REQUEST_GOAL) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            repeat ($urandom_range(1, 32)) send_request(random_draw());
         end else if (pick < 43) begin
            send_request(make_req(MODE_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom)));
         end else if (pick < 52) begin
            repeat ($urandom_range(1, 8)) send_request(req_type'($urandom));
         end else if (!full_scan_done) begin
            // whole frame plus up to four pulls past the end
            scan_run(COLUMNS * PAGES + 3 * PAGES + $urandom_range(4));
            full_scan_done = 1'b1;
         end else begin
            scan_run($urandom_range(1, 300));
         end
      end
      start <= 1'b0;

      drain_cycles = 0;
      while (awaited_count != 0 && drain_cycles < 10000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (16) @(posedge clock);

      if (failure_count == 0 && awaited_count == 0) begin
         $display("paged_pixel_framebuffer_refresher_top verification clean");
      end else begin
         $display("paged_pixel_framebuffer_refresher_top verification failed");
      end
      $finish;
   end

endmodule
